FILE: rtl/core/caf_pkg.sv
// Shared types, constants and the arctangent table for the complementary
// attitude filter. Used by caf_ctrl, caf_datapath and the top level.
package caf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 16;

  localparam int TABLE_FRAC = 24;   // fraction bits of the CORDIC angle accumulator
  localparam int CW         = 36;   // CORDIC x/y width
  localparam int ZW         = 35;   // CORDIC angle width
  localparam int MAW        = 35;   // multiplier operand a
  localparam int MBW        = 18;   // multiplier operand b
  localparam int PW         = MAW + MBW;
  localparam int CNT_W      = 5;

  localparam int SQRT_LAST  = 31;
  localparam int PREP_LAST  = 8;
  localparam int BLEND_LAST = 7;

  localparam logic [15:0] BLEND_RST = 16'd1311;
  localparam logic [15:0] STEP_RST  = 16'd328;
  localparam logic [15:0] GAIN_RST  = 16'd4000;

  localparam logic [1:0] REG_BLEND = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  localparam logic signed [ZW-1:0] Z_HALF = ZW'(180) <<< TABLE_FRAC;

  typedef enum logic [3:0] {
    M_NONE, M_GX, M_GY, M_GZ, M_STEP, M_AYY, M_AZZ,
    M_SPH, M_SPL, M_SRH, M_SRL, M_AP, M_AR
  } mul_sel_t;

  typedef enum logic [4:0] {
    A_NONE, A_CAPTURE, A_STPX, A_STPY, A_STPZ, A_SQ0, A_SQLOAD, A_SQRT,
    A_LDP, A_IT, A_LDR, A_STR, A_ACC_SET, A_ACC_ADD, A_PITCH, A_ROLL, A_OUT
  } act_t;

  typedef struct packed {
    mul_sel_t         mul_sel;
    act_t             act;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_SQRT  = 9'b000000100,
    S_LDP   = 9'b000001000,
    S_ITP   = 9'b000010000,
    S_LDR   = 9'b000100000,
    S_ITR   = 9'b001000000,
    S_BLEND = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ZW-1:0] atan_q24(input logic [CNT_W-1:0] i);
    int v;
    case (i)
      5'd0:  v = 754974720;
      5'd1:  v = 445687602;
      5'd2:  v = 235489088;
      5'd3:  v = 119537938;
      5'd4:  v = 60000934;
      5'd5:  v = 30029717;
      5'd6:  v = 15018523;
      5'd7:  v = 7509720;
      5'd8:  v = 3754917;
      5'd9:  v = 1877466;
      5'd10: v = 938734;
      5'd11: v = 469367;
      5'd12: v = 234684;
      5'd13: v = 117342;
      5'd14: v = 58671;
      5'd15: v = 29335;
      5'd16: v = 14668;
      5'd17: v = 7334;
      5'd18: v = 3667;
      5'd19: v = 1833;
      5'd20: v = 917;
      5'd21: v = 458;
      5'd22: v = 229;
      5'd23: v = 115;
      default: v = 0;
    endcase
    return ZW'(v);
  endfunction

endpackage

FILE: rtl/core/caf_ctrl.sv
// Sequencer of the attitude filter: walks the datapath through gyro scaling,
// square root, two CORDIC runs and the blend. Depends on caf_pkg.
module caf_ctrl import caf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  localparam logic [CNT_W-1:0] IT_LAST = CNT_W'(CORDIC_STEPS - 1);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt + 1'b1;
    cmd.mul_sel = M_NONE;
    cmd.act     = A_NONE;
    cmd.idx     = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.act    = A_CAPTURE;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        case (cnt)
          5'd0: cmd.mul_sel = M_GX;
          5'd1: cmd.mul_sel = M_STEP;
          5'd2: begin cmd.mul_sel = M_GY; cmd.act = A_STPX; end
          5'd3: cmd.mul_sel = M_STEP;
          5'd4: begin cmd.mul_sel = M_GZ; cmd.act = A_STPY; end
          5'd5: cmd.mul_sel = M_STEP;
          5'd6: begin cmd.mul_sel = M_AYY; cmd.act = A_STPZ; end
          5'd7: begin cmd.mul_sel = M_AZZ; cmd.act = A_SQ0; end
          default: cmd.act = A_SQLOAD;
        endcase
        if (cnt == CNT_W'(PREP_LAST)) begin
          state_next = S_SQRT;
          cnt_next   = '0;
        end
      end
      S_SQRT: begin
        cmd.act = A_SQRT;
        if (cnt == CNT_W'(SQRT_LAST)) state_next = S_LDP;
      end
      S_LDP: begin
        cmd.act    = A_LDP;
        cnt_next   = '0;
        state_next = S_ITP;
      end
      S_ITP: begin
        cmd.act = A_IT;
        if (cnt == IT_LAST) state_next = S_LDR;
      end
      S_LDR: begin
        cmd.act    = A_LDR;
        cnt_next   = '0;
        state_next = S_ITR;
      end
      S_ITR: begin
        cmd.act = A_IT;
        if (cnt == IT_LAST) begin
          state_next = S_BLEND;
          cnt_next   = '0;
        end
      end
      S_BLEND: begin
        case (cnt)
          5'd0: begin cmd.mul_sel = M_SPH; cmd.act = A_STR; end
          5'd1: begin cmd.mul_sel = M_SPL; cmd.act = A_ACC_SET; end
          5'd2: begin cmd.mul_sel = M_AP;  cmd.act = A_ACC_ADD; end
          5'd3: begin cmd.mul_sel = M_SRH; cmd.act = A_ACC_ADD; end
          5'd4: begin cmd.mul_sel = M_SRL; cmd.act = A_PITCH; end
          5'd5: begin cmd.mul_sel = M_AR;  cmd.act = A_ACC_ADD; end
          5'd6: cmd.act = A_ACC_ADD;
          default: cmd.act = A_ROLL;
        endcase
        if (cnt == CNT_W'(BLEND_LAST)) state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.act    = A_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_fin_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !sts.out_busy) |=> state == S_IDLE)
    else $error("finish state did not release");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == A_OUT) |-> !sts.out_busy)
    else $error("result loaded over a pending item");
  a_sqrt_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && cnt == CNT_W'(SQRT_LAST)) |=> state == S_LDP)
    else $error("square root ran past its length");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_PREP)
    else $error("accepted item did not start");
`endif

endmodule

FILE: rtl/core/caf_datapath.sv
// Datapath of the attitude filter: shared multiplier, accumulator, bit-serial
// square root, CORDIC vectoring unit, angle state and output register.
// Depends on caf_pkg; driven by caf_ctrl.
module caf_datapath import caf_pkg::*; #(
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [95:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [55:0] out_data
);

  localparam int AW   = ANGLE_FRACTION_BITS + 9;
  localparam int SUMW = ANGLE_FRACTION_BITS + 17;
  localparam int YW   = SUMW + 1;
  localparam int LO   = (SUMW + 1) / 2;
  localparam int ACCW = SUMW + 20;
  localparam int SH   = 32 - ANGLE_FRACTION_BITS;
  localparam int RSH  = TABLE_FRAC - ANGLE_FRACTION_BITS;
  localparam int OSH  = ANGLE_FRACTION_BITS - 8;
  localparam logic signed [AW-1:0] HALF   = AW'(180 * (1 << ANGLE_FRACTION_BITS));
  localparam logic signed [ZW-1:0] Z_RND  = ZW'(1 << (RSH - 1));

  logic [15:0] blend_weight, step_time, rate_gain;
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic signed [MAW-1:0] opa;
  logic signed [MBW-1:0] opb;
  logic signed [PW-1:0]  prod;
  logic signed [ACCW-1:0] acc;
  logic signed [SUMW-1:0] stp_x, stp_y, stp_z;
  logic signed [AW-1:0] pitch_angle, roll_angle, yaw_angle;
  logic signed [AW-1:0] grav_pitch, grav_roll;
  logic [31:0] sq;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic skip;

  logic [16:0] w1;
  logic signed [SUMW-1:0] sp, sr;
  logic [33:0] remsh, trial;
  logic signed [CW-1:0] xsrc, ysrc, xs, ys;
  logic signed [ZW-1:0] zr;
  logic signed [ACCW-1:0] bl;
  logic signed [AW-1:0] bl_sat;
  logic signed [YW-1:0] yw0, yw1, yw2;
  logic signed [AW-1:0] yaw_sat;

  assign w1 = 17'h10000 - {1'b0, blend_weight};
  assign sp = SUMW'(pitch_angle) + stp_x;
  assign sr = SUMW'(roll_angle) + stp_y;
  assign sts.out_busy = out_valid && !out_ready;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mul_sel)
      M_GX:   begin opa = MAW'(gx); opb = $signed({2'b0, rate_gain}); end
      M_GY:   begin opa = MAW'(gy); opb = $signed({2'b0, rate_gain}); end
      M_GZ:   begin opa = MAW'(gz); opb = $signed({2'b0, rate_gain}); end
      M_STEP: begin opa = MAW'($signed(prod[32:0])); opb = $signed({2'b0, step_time}); end
      M_AYY:  begin opa = MAW'(ay); opb = MBW'(ay); end
      M_AZZ:  begin opa = MAW'(az); opb = MBW'(az); end
      M_SPH:  begin opa = MAW'($signed(sp[SUMW-1:LO])); opb = $signed({1'b0, w1}); end
      M_SPL:  begin opa = $signed({{(MAW-LO){1'b0}}, sp[LO-1:0]}); opb = $signed({1'b0, w1}); end
      M_SRH:  begin opa = MAW'($signed(sr[SUMW-1:LO])); opb = $signed({1'b0, w1}); end
      M_SRL:  begin opa = $signed({{(MAW-LO){1'b0}}, sr[LO-1:0]}); opb = $signed({1'b0, w1}); end
      M_AP:   begin opa = MAW'(grav_pitch); opb = $signed({2'b0, blend_weight}); end
      M_AR:   begin opa = MAW'(grav_roll); opb = $signed({2'b0, blend_weight}); end
      default: ;
    endcase
  end

  // square root step: two radicand bits per cycle
  assign remsh = {rem[31:0], rad[63:62]};
  assign trial = {root, 2'b01};

  // CORDIC source vector for the run being loaded
  always_comb begin
    if (cmd.act == A_LDP) begin
      ysrc = -(CW'(ax) <<< 16);
      xsrc = $signed({4'b0, root});
    end else begin
      ysrc = CW'(ay) <<< 16;
      xsrc = CW'(az) <<< 16;
    end
  end
  assign xs = cx >>> cmd.idx;
  assign ys = cy >>> cmd.idx;
  assign zr = (cz + Z_RND) >>> RSH;

  // blend result, saturated to a half turn
  assign bl = acc >>> 16;
  always_comb begin
    if (bl > ACCW'(HALF))       bl_sat = HALF;
    else if (bl < -ACCW'(HALF)) bl_sat = -HALF;
    else                        bl_sat = AW'(bl);
  end

  // yaw: wrap once each way, then saturate
  always_comb begin
    yw0 = YW'(yaw_angle) + YW'(stp_z);
    yw1 = (yw0 > YW'(HALF)) ? yw0 - (YW'(HALF) <<< 1) : yw0;
    yw2 = (yw1 < -YW'(HALF)) ? yw1 + (YW'(HALF) <<< 1) : yw1;
    if (yw2 > YW'(HALF))       yaw_sat = HALF;
    else if (yw2 < -YW'(HALF)) yaw_sat = -HALF;
    else                       yaw_sat = AW'(yw2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= BLEND_RST;
      step_time    <= STEP_RST;
      rate_gain    <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND: blend_weight <= cfg_data;
        REG_STEP:  step_time    <= cfg_data;
        REG_GAIN:  rate_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_angle <= '0;
      roll_angle  <= '0;
      yaw_angle   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.act == A_PITCH) pitch_angle <= bl_sat;
      if (cmd.act == A_ROLL) begin
        roll_angle <= bl_sat;
        yaw_angle  <= yaw_sat;
      end
      if (cmd.act == A_OUT)  out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    case (cmd.act)
      A_CAPTURE: begin
        ax <= $signed(in_data[15:0]);
        ay <= $signed(in_data[31:16]);
        az <= $signed(in_data[47:32]);
        gx <= $signed(in_data[63:48]);
        gy <= $signed(in_data[79:64]);
        gz <= $signed(in_data[95:80]);
      end
      A_STPX: stp_x <= SUMW'(prod >>> SH);
      A_STPY: stp_y <= SUMW'(prod >>> SH);
      A_STPZ: stp_z <= SUMW'(prod >>> SH);
      A_SQ0:  sq <= prod[31:0];
      A_SQLOAD: begin
        rad  <= {sq + prod[31:0], 32'b0};
        rem  <= '0;
        root <= '0;
      end
      A_SQRT: begin
        rad <= rad << 2;
        if (remsh >= trial) begin
          rem  <= remsh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= remsh;
          root <= {root[30:0], 1'b0};
        end
      end
      A_LDP, A_LDR: begin
        if (cmd.act == A_LDR) grav_pitch <= AW'(zr);
        skip <= (ysrc == '0);
        if (xsrc < 0) begin
          // rotate by a half turn, sign following y
          cx <= -xsrc;
          cy <= -ysrc;
          cz <= (ysrc >= 0) ? Z_HALF : -Z_HALF;
        end else begin
          cx <= xsrc;
          cy <= ysrc;
          cz <= '0;
        end
      end
      A_IT: begin
        if (!skip) begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_q24(cmd.idx);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_q24(cmd.idx);
          end
        end
      end
      A_STR:     grav_roll <= AW'(zr);
      A_ACC_SET: acc <= ACCW'(prod) <<< LO;
      A_ACC_ADD: acc <= acc + ACCW'(prod);
      A_PITCH:   acc <= ACCW'(prod) <<< LO;
      A_OUT: begin
        out_data <= {5'b0, yaw_angle[AW-1:OSH], roll_angle[AW-1:OSH],
                     pitch_angle[AW-1:OSH]};
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/complementary_attitude_filter_top.sv
// Complementary attitude filter: pitch/roll from accelerometer CORDIC blended
// with integrated gyro rates, yaw integrated and wrapped.
// The time from accept to m_tvalid is set by the bit-serial square root, the two
// CORDIC runs and any wait for the output register to be free.
// One item in flight: the next is accepted once the last has gone to the output register.
// Reset (rst, synchronous): angles zero, registers to their defaults.
module complementary_attitude_filter_top import caf_pkg::*; #(
  parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch_out, roll_out, yaw_out (17 bits each), 5 zero bits
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  caf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  caf_datapath #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
